// ===== rtl/oahs_pkg.sv =====
// Shared types and codes for the open addressing hash set.
// No dependencies.
package oahs_pkg;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_CONTAINS = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_STEAL    = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CLEAR,
        S_COPY_RD,
        S_COPY_WR,
        S_RH_WAIT,
        S_RH_RD,
        S_RH_PROBE_RD,
        S_RH_PROBE_CHK,
        S_DONE
    } state_t;

endpackage

// ===== rtl/open_addressing_hash_set_top.sv =====
// Open addressing hash set: top level with tables, sequencer and probe unit.
// Depends on oahs_pkg.
// Each probe step reads a bucket, then checks it; a request ends in a done state
// that raises done. Clear walks every bucket; unused request codes go straight to done.
// Rehash first copies every bucket to a scratch table and empties it, then skips
// each empty or dead bucket and probes anew for each live one. One item at a time; no stalls.
// Reset starts a pass that marks every bucket empty; busy is high.
module open_addressing_hash_set_top #(
    parameter int TABLE_SIZE = 1024,
    parameter int KEY_WIDTH  = 32,
    parameter int HASH_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [KEY_WIDTH-1:0]  key,
    input  logic [HASH_WIDTH-1:0] key_hash,
    output logic                  done,
    output logic                  found,
    output logic [1:0]            status,
    output logic [31:0]           key_out,
    output logic [10:0]           live_count
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LIMIT = CW'(TABLE_SIZE - TABLE_SIZE / 4);
    localparam logic [HASH_WIDTH-1:0] H_EMPTY = '1;
    localparam logic [HASH_WIDTH-1:0] H_DEL = H_EMPTY - HASH_WIDTH'(1);
    localparam logic [HASH_WIDTH-1:0] H_REMAP = H_EMPTY - HASH_WIDTH'(2);

    logic [HASH_WIDTH-1:0] b_hash [TABLE_SIZE];
    logic [KEY_WIDTH-1:0]  b_key  [TABLE_SIZE];
    logic [HASH_WIDTH-1:0] s_hash [TABLE_SIZE];
    logic [KEY_WIDTH-1:0]  s_key  [TABLE_SIZE];

    oahs_pkg::state_t state_reg, state_next;
    logic [2:0]            req_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [HASH_WIDTH-1:0] hash_reg;
    logic [KEY_WIDTH-1:0]  sv_key_reg;
    logic [HASH_WIDTH-1:0] sv_hash_reg;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         walk_reg, walk_next;
    logic [CW-1:0]         live_reg, live_next, tomb_reg, tomb_next;
    logic                  rehashed_reg, rehashed_next;
    logic [HASH_WIDTH-1:0] rd_hash_reg, rs_hash_reg;
    logic [KEY_WIDTH-1:0]  rd_key_reg, rs_key_reg;
    logic                  found_next, done_next;
    logic [1:0]            status_next;
    logic [31:0]           kout_next;

    logic                  b_we, b_kwe, s_we, restore;
    logic [AW-1:0]         b_addr, s_addr;
    logic [HASH_WIDTH-1:0] b_wh;
    logic [KEY_WIDTH-1:0]  b_wk;
    logic [HASH_WIDTH-1:0] eff_hash;
    logic                  is_empty, is_match;

    always_comb
    begin
        eff_hash = key_hash;
        if (key_hash == H_EMPTY || key_hash == H_DEL)
        begin
            eff_hash = H_REMAP;
        end
    end

    assign is_empty = rd_hash_reg == H_EMPTY;
    assign is_match = rd_hash_reg == hash_reg && rd_key_reg == key_reg;
    assign busy = state_reg != oahs_pkg::S_IDLE;

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_hash[b_addr] <= b_wh;
        end
        if (b_kwe)
        begin
            b_key[b_addr] <= b_wk;
        end
        rd_hash_reg <= b_hash[b_addr];
        rd_key_reg  <= b_key[b_addr];
        if (s_we)
        begin
            s_hash[s_addr] <= rd_hash_reg;
            s_key[s_addr]  <= rd_key_reg;
        end
        rs_hash_reg <= s_hash[s_addr];
        rs_key_reg  <= s_key[s_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= oahs_pkg::S_INIT;
            live_reg     <= '0;
            tomb_reg     <= '0;
            done         <= 1'b0;
            rehashed_reg <= 1'b0;
            walk_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            tomb_reg     <= tomb_next;
            done         <= done_next;
            rehashed_reg <= rehashed_next;
            walk_reg     <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg  <= req_type;
            key_reg  <= key;
            hash_reg <= eff_hash;
        end
        else if (state_reg == oahs_pkg::S_RH_RD)
        begin
            hash_reg <= rs_hash_reg;
            key_reg  <= rs_key_reg;
        end
        else if (restore)
        begin
            hash_reg <= sv_hash_reg;
            key_reg  <= sv_key_reg;
        end
        idx_reg  <= idx_next;
        n_reg    <= n_next;
        found    <= found_next;
        status   <= status_next;
        key_out  <= kout_next;
        live_count <= 11'(live_next);
    end

    // saved request across rehash
    always_ff @(posedge clk)
    begin
        if (state_reg == oahs_pkg::S_PROBE_CHK && state_next == oahs_pkg::S_COPY_RD)
        begin
            sv_key_reg  <= key_reg;
            sv_hash_reg <= hash_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        walk_next = walk_reg;
        live_next = live_reg;
        tomb_next = tomb_reg;
        rehashed_next = rehashed_reg;
        done_next = 1'b0;
        found_next = found;
        status_next = status;
        kout_next = key_out;
        b_we = 1'b0;
        b_kwe = 1'b0;
        s_we = 1'b0;
        b_addr = idx_reg;
        s_addr = walk_reg[AW-1:0];
        b_wh = hash_reg;
        b_wk = key_reg;
        restore = 1'b0;
        unique case (state_reg)
            oahs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    found_next = 1'b0;
                    status_next = oahs_pkg::ST_OK;
                    kout_next = '0;
                    rehashed_next = 1'b0;
                    idx_next = eff_hash[AW-1:0];
                    n_next = '0;
                    walk_next = '0;
                    case (req_type) inside
                        oahs_pkg::REQ_INSERT, oahs_pkg::REQ_CONTAINS,
                        oahs_pkg::REQ_REMOVE, oahs_pkg::REQ_STEAL:
                            state_next = oahs_pkg::S_PROBE_RD;
                        oahs_pkg::REQ_CLEAR:
                            state_next = oahs_pkg::S_CLEAR;
                        default:
                            state_next = oahs_pkg::S_DONE;
                    endcase
                end
            end
            oahs_pkg::S_INIT, oahs_pkg::S_CLEAR:
            begin
                b_addr = walk_reg[AW-1:0];
                b_we = 1'b1;
                b_wh = H_EMPTY;
                if (walk_reg == CW'(TABLE_SIZE - 1))
                begin
                    walk_next = '0;
                    live_next = '0;
                    tomb_next = '0;
                    state_next = (state_reg == oahs_pkg::S_INIT) ? oahs_pkg::S_IDLE
                                                                 : oahs_pkg::S_DONE;
                end
                else
                begin
                    walk_next = walk_reg + CW'(1);
                end
            end
            oahs_pkg::S_PROBE_RD:
            begin
                state_next = oahs_pkg::S_PROBE_CHK;
            end
            oahs_pkg::S_PROBE_CHK:
            begin
                if (!is_empty && is_match)
                begin
                    found_next = 1'b1;
                    state_next = oahs_pkg::S_DONE;
                    if (req_reg != oahs_pkg::REQ_REMOVE)
                    begin
                        kout_next = 32'(rd_key_reg);
                    end
                    if (req_reg == oahs_pkg::REQ_INSERT)
                    begin
                        b_kwe = 1'b1;
                    end
                    else if (req_reg != oahs_pkg::REQ_CONTAINS)
                    begin
                        b_we = 1'b1;
                        b_wh = H_DEL;
                        live_next = live_reg - CW'(1);
                        tomb_next = tomb_reg + CW'(1);
                    end
                end
                else if (is_empty || n_reg == CW'(TABLE_SIZE - 1))
                begin
                    state_next = oahs_pkg::S_DONE;
                    if (req_reg != oahs_pkg::REQ_INSERT)
                    begin
                        status_next = oahs_pkg::ST_NOT_FOUND;
                    end
                    else if (live_reg >= LIMIT)
                    begin
                        status_next = oahs_pkg::ST_FULL;
                    end
                    else if (!rehashed_reg && live_reg + tomb_reg >= LIMIT)
                    begin
                        rehashed_next = 1'b1;
                        walk_next = '0;
                        state_next = oahs_pkg::S_COPY_RD;
                    end
                    else if (!is_empty)
                    begin
                        status_next = oahs_pkg::ST_FULL;
                    end
                    else
                    begin
                        b_we = 1'b1;
                        b_kwe = 1'b1;
                        live_next = live_reg + CW'(1);
                    end
                end
                else
                begin
                    n_next = n_reg + CW'(1);
                    idx_next = idx_reg + AW'(n_reg + CW'(1));
                    state_next = oahs_pkg::S_PROBE_RD;
                end
            end
            oahs_pkg::S_COPY_RD:
            begin
                b_addr = walk_reg[AW-1:0];
                state_next = oahs_pkg::S_COPY_WR;
            end
            oahs_pkg::S_COPY_WR:
            begin
                b_addr = walk_reg[AW-1:0];
                b_we = 1'b1;
                b_wh = H_EMPTY;
                s_we = 1'b1;
                if (walk_reg == CW'(TABLE_SIZE - 1))
                begin
                    walk_next = '0;
                    tomb_next = '0;
                    state_next = oahs_pkg::S_RH_WAIT;
                end
                else
                begin
                    walk_next = walk_reg + CW'(1);
                    state_next = oahs_pkg::S_COPY_RD;
                end
            end
            oahs_pkg::S_RH_RD:
            begin
                // scratch read issued last cycle for walk_reg
                state_next = oahs_pkg::S_RH_PROBE_RD;
                if (rs_hash_reg == H_DEL || rs_hash_reg == H_EMPTY)
                begin
                    state_next = oahs_pkg::S_RH_PROBE_CHK;
                end
                idx_next = rs_hash_reg[AW-1:0];
                n_next = '0;
            end
            oahs_pkg::S_RH_PROBE_RD:
            begin
                state_next = oahs_pkg::S_RH_PROBE_CHK;
            end
            oahs_pkg::S_RH_PROBE_CHK:
            begin
                if (hash_reg == H_DEL || hash_reg == H_EMPTY || is_empty)
                begin
                    if (hash_reg != H_DEL && hash_reg != H_EMPTY)
                    begin
                        b_we = 1'b1;
                        b_kwe = 1'b1;
                    end
                    if (walk_reg == CW'(TABLE_SIZE - 1))
                    begin
                        restore = 1'b1;
                        idx_next = sv_hash_reg[AW-1:0];
                        n_next = '0;
                        state_next = oahs_pkg::S_PROBE_RD;
                    end
                    else
                    begin
                        walk_next = walk_reg + CW'(1);
                        s_addr = AW'(walk_reg + CW'(1));
                        state_next = oahs_pkg::S_RH_WAIT;
                    end
                end
                else
                begin
                    n_next = n_reg + CW'(1);
                    idx_next = idx_reg + AW'(n_reg + CW'(1));
                    state_next = oahs_pkg::S_RH_PROBE_RD;
                end
            end
            oahs_pkg::S_RH_WAIT:
            begin
                state_next = oahs_pkg::S_RH_RD;
            end
            oahs_pkg::S_DONE:
            begin
                done_next = 1'b1;
                state_next = oahs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = oahs_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done);
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == oahs_pkg::ST_OK || status == oahs_pkg::ST_NOT_FOUND ||
                  status == oahs_pkg::ST_FULL));
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> status == oahs_pkg::ST_OK);
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIMIT);
`endif
endmodule

// ===== verif/tb_open_addressing_hash_set_top.sv =====
// Testbench for the open addressing hash set: directed and random requests,
// each result compared against a behavioral copy of the table.
// Depends on oahs_pkg and open_addressing_hash_set_top.
`timescale 1ns / 100ps

module tb_open_addressing_hash_set_top;

    localparam int TSIZE = 1024;
    localparam int LOAD_MAX = TSIZE - (TSIZE >> 2);
    localparam logic [31:0] H_EMPTY = 32'hFFFF_FFFF;
    localparam logic [31:0] H_DELETED = 32'hFFFF_FFFE;
    localparam logic [31:0] H_REMAP = 32'hFFFF_FFFD;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic        found;
        logic [1:0]  status;
        logic [31:0] key_out;
        logic [10:0] live_count;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic        done;
    logic        found;
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [10:0] live_count;

    logic [31:0] tbl_hash [TSIZE];
    logic [31:0] tbl_key [TSIZE];
    int          n_live;
    int          n_tomb;
    outcome_t    pending_q [$];
    logic [31:0] key_pool [$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          idle_cycles;

    open_addressing_hash_set_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .key        (key),
        .key_hash   (key_hash),
        .done       (done),
        .found      (found),
        .status     (status),
        .key_out    (key_out),
        .live_count (live_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_slot(input logic [31:0] h, input logic [31:0] k,
                                     output int slot);
        int idx;
        idx = h & (TSIZE - 1);
        slot = 0;
        for (int n = 0; n < TSIZE; n++)
        begin
            if (tbl_hash[idx] == H_EMPTY)
            begin
                slot = idx;
                return 0;
            end
            if (tbl_hash[idx] == h && tbl_key[idx] == k)
            begin
                slot = idx;
                return 1;
            end
            idx = (idx + n + 1) & (TSIZE - 1);
        end
        return -1;
    endfunction

    function automatic void rebuild_table();
        logic [31:0] old_hash [TSIZE];
        logic [31:0] old_key [TSIZE];
        int idx;
        old_hash = tbl_hash;
        old_key = tbl_key;
        foreach (tbl_hash[i]) tbl_hash[i] = H_EMPTY;
        n_tomb = 0;
        for (int i = 0; i < TSIZE; i++)
        begin
            if (old_hash[i] == H_EMPTY || old_hash[i] == H_DELETED) continue;
            idx = old_hash[i] & (TSIZE - 1);
            for (int n = 0; n < TSIZE; n++)
            begin
                if (tbl_hash[idx] == H_EMPTY)
                begin
                    tbl_hash[idx] = old_hash[i];
                    tbl_key[idx] = old_key[i];
                    break;
                end
                idx = (idx + n + 1) & (TSIZE - 1);
            end
        end
    endfunction

    function automatic outcome_t apply_request(input logic [2:0] rq,
                                               input logic [31:0] k,
                                               input logic [31:0] hin);
        outcome_t o;
        logic [31:0] h;
        int r;
        int slot;
        o = '0;
        h = (hin == H_EMPTY || hin == H_DELETED) ? H_REMAP : hin;
        case (rq) inside
            oahs_pkg::REQ_INSERT:
            begin
                r = find_slot(h, k, slot);
                if (r == 1)
                begin
                    o.found = 1'b1;
                    o.key_out = tbl_key[slot];
                    tbl_key[slot] = k;
                end
                else if (n_live >= LOAD_MAX)
                    o.status = oahs_pkg::ST_FULL;
                else
                begin
                    if (n_live + n_tomb >= LOAD_MAX)
                    begin
                        rebuild_table();
                        r = find_slot(h, k, slot);
                    end
                    if (r == 0)
                    begin
                        tbl_hash[slot] = h;
                        tbl_key[slot] = k;
                        n_live++;
                    end
                    else
                        o.status = oahs_pkg::ST_FULL;
                end
            end
            oahs_pkg::REQ_CONTAINS, oahs_pkg::REQ_REMOVE, oahs_pkg::REQ_STEAL:
            begin
                r = find_slot(h, k, slot);
                if (r == 1)
                begin
                    o.found = 1'b1;
                    if (rq != oahs_pkg::REQ_REMOVE) o.key_out = tbl_key[slot];
                    if (rq != oahs_pkg::REQ_CONTAINS)
                    begin
                        tbl_hash[slot] = H_DELETED;
                        n_live--;
                        n_tomb++;
                    end
                end
                else
                    o.status = oahs_pkg::ST_NOT_FOUND;
            end
            oahs_pkg::REQ_CLEAR:
            begin
                foreach (tbl_hash[i]) tbl_hash[i] = H_EMPTY;
                n_live = 0;
                n_tomb = 0;
            end
            default: ;
        endcase
        o.live_count = n_live[10:0];
        return o;
    endfunction

    task automatic pause_random();
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic send_item(input logic [2:0] rq, input logic [31:0] k,
                             input logic [31:0] h);
        start <= 1'b1;
        req_type <= rq;
        key <= k;
        key_hash <= h;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q.push_back(apply_request(rq, k, h));
        n_sent++;
        start <= 1'b0;
        @(posedge clk);
        pause_random();
    endtask

    function automatic logic [31:0] hash_of(input logic [31:0] k);
        return (k * 32'h9E37_79B9) ^ (k >> 7);
    endfunction

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no item outstanding");
                n_errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                n_checked++;
                if (found !== e.found)
                begin
                    $error("found: expected %0d actual %0d", e.found, found);
                    n_errors++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, status);
                    n_errors++;
                end
                if (key_out !== e.key_out)
                begin
                    $error("key_out: expected %h actual %h", e.key_out, key_out);
                    n_errors++;
                end
                if (live_count !== e.live_count)
                begin
                    $error("live_count: expected %0d actual %0d", e.live_count,
                           live_count);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d items outstanding", pending_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(oahs_pkg::REQ_CONTAINS, 32'h0, 32'h0);
        send_item(oahs_pkg::REQ_INSERT, 32'h0, 32'h0);
        send_item(oahs_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(oahs_pkg::REQ_INSERT, 32'h1234_5678, 32'hFFFF_FFFE);
        send_item(oahs_pkg::REQ_INSERT, 32'hAAAA_5555, 32'hFFFF_FFFD);
        send_item(oahs_pkg::REQ_CONTAINS, 32'h1234_5678, 32'hFFFF_FFFF);
        send_item(oahs_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(oahs_pkg::REQ_INSERT, 32'h5555_AAAA, 32'h0);
        send_item(oahs_pkg::REQ_CONTAINS, 32'h5555_AAAA, 32'h0);
        send_item(oahs_pkg::REQ_STEAL, 32'h0, 32'h0);
        send_item(oahs_pkg::REQ_STEAL, 32'h0, 32'h0);
        send_item(oahs_pkg::REQ_REMOVE, 32'h5555_AAAA, 32'h0);
        send_item(oahs_pkg::REQ_REMOVE, 32'h5555_AAAA, 32'h0);
        send_item(oahs_pkg::REQ_CONTAINS, 32'h5555_AAAA, 32'h0);
        send_item(oahs_pkg::REQ_INSERT, 32'h5555_AAAA, 32'h0);
        send_item(3'd5, 32'h1, 32'h1);
        send_item(3'd6, 32'hFFFF_FFFF, 32'h0);
        send_item(3'd7, 32'h0, 32'hFFFF_FFFF);
        send_item(oahs_pkg::REQ_CLEAR, 32'h0, 32'h0);
        send_item(oahs_pkg::REQ_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    endtask

    task automatic test_fill_and_rehash();
        logic [31:0] k;
        for (int i = 0; i < LOAD_MAX + 4; i++)
        begin
            k = $urandom();
            send_item(oahs_pkg::REQ_INSERT, k,
                      (i % 50 == 0) ? {22'h0, k[9:0]} : hash_of(k));
            key_pool.push_back(k);
        end
        for (int i = 0; i < 60; i++)
            send_item(oahs_pkg::REQ_STEAL, key_pool[i], hash_of(key_pool[i]));
        for (int i = 0; i < 70; i++)
        begin
            k = $urandom();
            send_item(oahs_pkg::REQ_INSERT, k, hash_of(k));
            key_pool.push_back(k);
        end
    endtask

    task automatic test_random_mix();
        logic [31:0] k;
        logic [31:0] h;
        logic [2:0]  rq;
        int          pick;
        key_pool.delete();
        for (int i = 0; i < 930; i++)
        begin
            pick = $urandom_range(0, 99);
            if (key_pool.size() > 0 && pick < 55)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
            begin
                k = $urandom();
                if (key_pool.size() < 400) key_pool.push_back(k);
            end
            h = hash_of(k);
            if ($urandom_range(0, 19) == 0) h = {$urandom_range(0, 1) ? 22'h3FFFFF : 22'h0,
                                                 10'($urandom())};
            if ($urandom_range(0, 49) == 0) h = $urandom_range(0, 1) ? H_EMPTY : H_DELETED;
            pick = $urandom_range(0, 199);
            if (pick < 80) rq = oahs_pkg::REQ_INSERT;
            else if (pick < 120) rq = oahs_pkg::REQ_CONTAINS;
            else if (pick < 155) rq = oahs_pkg::REQ_REMOVE;
            else if (pick < 195) rq = oahs_pkg::REQ_STEAL;
            else if (pick < 197) rq = oahs_pkg::REQ_CLEAR;
            else rq = 3'($urandom_range(5, 7));
            send_item(rq, k, h);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = oahs_pkg::REQ_INSERT;
        key = '0;
        key_hash = '0;
        n_sent = 0;
        foreach (tbl_hash[i]) tbl_hash[i] = H_EMPTY;
        foreach (tbl_key[i]) tbl_key[i] = '0;
        n_live = 0;
        n_tomb = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_rehash();
        test_random_mix();
        while (pending_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d requests sent, %0d results checked: insert, lookup, remove,",
                 n_sent, n_checked);
        $display("steal, clear, reserved hashes, full table and rehash were exercised");
        if (n_errors == 0 && pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
